// File: hw/rtl/shash_pkg.sv
// Shared types, constants and round table for the SHA-256 stream hasher.
// Depends on nothing; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package shash_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 61;
  localparam int POS_W   = 6;
  localparam int ROUND_W = 6;
  localparam int WIDX_W  = 3;

  localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
  localparam logic [POS_W-1:0]   POS_LEN    = 6'd56;
  localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
  localparam logic [WIDX_W-1:0]  WIDX_LAST  = 3'd7;
  localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;

  localparam logic [WORD_W-1:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD_80,
    ST_PAD_ZERO,
    ST_PAD_LEN,
    ST_COMP_INIT,
    ST_COMP_ROUND,
    ST_COMP_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic                wr_byte;
    byte_sel_t           byte_sel;
    logic                count_msg;
    logic                init_v;
    logic                do_round;
    logic [ROUND_W-1:0]  round_idx;
    logic                finalize;
    logic                clear;
    logic [WIDX_W-1:0]   word_idx;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
  } status_t;

endpackage

// File: hw/rtl/sha256_stream_hasher_top.sv
// Top level of the SHA-256 stream hasher: byte stream in, digest words out.
// Depends on shash_pkg, shash_ctrl and shash_datapath.
`timescale 1ns / 1ps

// Usage:
//   Slave stream: one message byte per word in s_axis_tdata, s_axis_tuser
//   high when the byte belongs to the message, s_axis_tlast high on the final
//   word. A final word with tuser low ends the message without a byte, so an
//   empty message is a single such word.
//   Master stream: eight words carry the digest, word 0 first; tdata holds
//   the 32-bit digest word, tuser its index, tlast marks the eighth word.
//   Flow: a byte that completes a 64-byte block runs a compression (load, 64
//   rounds, hash update) on the single shared round unit; no byte is taken
//   meanwhile. The final word adds pad, zero and length bytes to the end of
//   the block, an idle step where the zero fill meets the length field, and
//   a compression per padding block (one or two); then the digest words
//   follow, one per cycle the receiver is ready.
//   s_axis_tready is high only while the block waits for a byte.
//   A stalled receiver holds the digest word steady; no new byte is taken
//   until the eighth digest word is accepted, after which the hash state
//   returns to its initial values for the next message.
//   Reset (rst, synchronous) loads the initial hash values and clears the
//   byte count, dropping any partial message.

module sha256_stream_hasher_top
  import shash_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast
);

  cmd_t    cmd;
  status_t status;

  shash_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_has    (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  shash_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_byte     (s_axis_tdata),
    .cmd         (cmd),
    .status      (status),
    .digest_word (m_axis_tdata)
  );

  assign m_axis_tuser = cmd.word_idx;
  assign m_axis_tlast = (cmd.word_idx == WIDX_LAST);

endmodule

// File: hw/rtl/shash_ctrl.sv
// Controller for the SHA-256 stream hasher: sequences byte intake, padding,
// compression rounds and digest output. Depends on shash_pkg.
`timescale 1ns / 1ps

module shash_ctrl
  import shash_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_has,
  input  logic    in_last,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t              state, state_next;
  state_t              ret, ret_next;
  logic [ROUND_W-1:0]  round, round_next;
  logic [WIDX_W-1:0]   widx, widx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      round <= '0;
      widx  <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      round <= round_next;
      widx  <= widx_next;
    end
  end

  always_comb begin
    state_next    = state;
    ret_next      = ret;
    round_next    = round;
    widx_next     = widx;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.byte_sel  = SEL_MSG;
    cmd.round_idx = round;
    cmd.word_idx  = widx;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_byte   = in_has;
          cmd.count_msg = in_has;
          if (in_has && status.pos == POS_LAST) begin
            state_next = ST_COMP_INIT;
            ret_next   = in_last ? ST_PAD_80 : ST_IDLE;
          end else if (in_last) begin
            state_next = ST_PAD_80;
          end
        end
      end
      ST_PAD_80: begin
        cmd.wr_byte  = 1'b1;
        cmd.byte_sel = SEL_PAD;
        if (status.pos == POS_LAST) begin
          state_next = ST_COMP_INIT;
          ret_next   = ST_PAD_ZERO;
        end else begin
          state_next = ST_PAD_ZERO;
        end
      end
      ST_PAD_ZERO: begin
        if (status.pos == POS_LEN) begin
          state_next = ST_PAD_LEN;
        end else begin
          cmd.wr_byte  = 1'b1;
          cmd.byte_sel = SEL_ZERO;
          if (status.pos == POS_LAST) begin
            state_next = ST_COMP_INIT;
            ret_next   = ST_PAD_ZERO;
          end
        end
      end
      ST_PAD_LEN: begin
        cmd.wr_byte  = 1'b1;
        cmd.byte_sel = SEL_LEN;
        if (status.pos == POS_LAST) begin
          state_next = ST_COMP_INIT;
          ret_next   = ST_OUT;
        end
      end
      ST_COMP_INIT: begin
        cmd.init_v = 1'b1;
        round_next = '0;
        state_next = ST_COMP_ROUND;
      end
      ST_COMP_ROUND: begin
        cmd.do_round = 1'b1;
        round_next   = round + 1'b1;
        if (round == ROUND_LAST) begin
          state_next = ST_COMP_FIN;
        end
      end
      ST_COMP_FIN: begin
        cmd.finalize = 1'b1;
        widx_next    = '0;
        state_next   = ret;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          widx_next = widx + 1'b1;
          if (widx == WIDX_LAST) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/shash_datapath.sv
// Datapath for the SHA-256 stream hasher: message schedule shift line,
// working variables, hash words, block position and byte count. Depends on shash_pkg.
`timescale 1ns / 1ps

module shash_datapath
  import shash_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] in_byte,
  input  cmd_t              cmd,
  output status_t           status,
  output logic [WORD_W-1:0] digest_word
);

  logic [WORD_W-1:0]  hash [8];
  logic [WORD_W-1:0]  v [8];
  logic [WORD_W-1:0]  w [16];
  logic [23:0]        acc;
  logic [POS_W-1:0]   pos;
  logic [COUNT_W-1:0] count;

  logic [63:0]        bit_len;
  logic [BYTE_W-1:0]  len_byte;
  logic [BYTE_W-1:0]  wr_val;
  logic [WORD_W-1:0]  new_word;
  logic [WORD_W-1:0]  sg0, sg1, w_next;
  logic [WORD_W-1:0]  big0, big1, choose, major, t1, t2;

  assign bit_len  = {count, 3'b000};
  assign len_byte = bit_len[{~pos[2:0], 3'b000} +: 8];

  always_comb begin
    unique case (cmd.byte_sel)
      SEL_MSG:  wr_val = in_byte;
      SEL_PAD:  wr_val = PAD_BYTE;
      SEL_ZERO: wr_val = '0;
      SEL_LEN:  wr_val = len_byte;
      default:  wr_val = '0;
    endcase
  end

  assign new_word = {acc, wr_val};

  assign sg0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
  assign sg1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]}
             ^ (w[14] >> 10);
  assign w_next = w[0] + sg0 + w[9] + sg1;

  assign big1   = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]}
                ^ {v[4][24:0], v[4][31:25]};
  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1     = v[7] + big1 + choose + K_TABLE[cmd.round_idx] + w[0];
  assign big0   = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]}
                ^ {v[0][21:0], v[0][31:22]};
  assign major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2     = big0 + major;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      pos   <= '0;
      count <= '0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= H_INIT[i];
      end
    end else begin
      if (cmd.wr_byte) begin
        pos <= pos + 1'b1;
      end
      if (cmd.count_msg) begin
        count <= count + 1'b1;
      end
      if (cmd.finalize) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + v[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      acc <= new_word[23:0];
      if (pos[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= new_word;
      end
    end else if (cmd.do_round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_next;
    end
    if (cmd.init_v) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= hash[i];
      end
    end else if (cmd.do_round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  assign status.pos  = pos;
  assign digest_word = hash[cmd.word_idx];

endmodule
